### src/lpnr_pkg.sv
// ----------------------------------------------------------------------------
// lpnr_pkg: shared types for the linear probe name registry
// Opcodes, result status codes and sequencer states.
// ----------------------------------------------------------------------------
package lpnr_pkg;

	localparam logic OP_REGISTER = 1'b0;
	localparam logic OP_LOOKUP   = 1'b1;

	typedef enum logic [2:0] {
		ST_IGNORED = 3'd0,
		ST_PROBED  = 3'd1,
		ST_HOME    = 3'd2,
		ST_HIT     = 3'd3,
		ST_MISS    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_REM,
		S_ISSUE,
		S_PROBE,
		S_EMIT
	} state_t;

endpackage

### src/lpnr_req_if.sv
// ----------------------------------------------------------------------------
// lpnr_req_if: request channel of the name registry
// Valid/ready handshake carrying opcode, id and name payload.
// ----------------------------------------------------------------------------
interface lpnr_req_if #(
	parameter int ID_W   = 32,
	parameter int NAME_W = 64
);
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [ID_W-1:0]   key_id;
	logic [NAME_W-1:0] name_value;

	modport source (output valid, output opcode, output key_id, output name_value,
		input ready);
	modport sink (input valid, input opcode, input key_id, input name_value,
		output ready);
endinterface

### src/lpnr_rsp_if.sv
// ----------------------------------------------------------------------------
// lpnr_rsp_if: response channel of the name registry
// Valid/ready handshake carrying status and name payload.
// ----------------------------------------------------------------------------
interface lpnr_rsp_if #(
	parameter int NAME_W = 64
);
	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic [NAME_W-1:0] name_out;

	modport source (output valid, output status, output name_out, input ready);
	modport sink (input valid, input status, input name_out, output ready);
endinterface

### src/lpnr_ram.sv
// ----------------------------------------------------------------------------
// lpnr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lpnr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### src/linear_probe_name_registry.sv
// ----------------------------------------------------------------------------
// linear_probe_name_registry: open-addressed id-to-name table, linear probing
// Flow: requests with id 0, and registers before any lookup has armed the table, go
//   straight from idle to the emit state; other requests pass the two multiply states,
//   then the remainder, issue and probe states before emit. One request at a time,
//   paced by the shared multiplier for the home bucket and one slot read per cycle.
// Reset: clearing pass over the id RAM, no request taken meanwhile.
// ----------------------------------------------------------------------------
module linear_probe_name_registry #(
	parameter int SLOT_COUNT = 256,
	parameter int ID_WIDTH   = 32,
	parameter int NAME_WIDTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	lpnr_req_if.sink   req,
	lpnr_rsp_if.source rsp
);
	// Ids are held to at most 32 bits.
	localparam int KEY_W = (ID_WIDTH < 32) ? ID_WIDTH : 32;
	localparam int IW    = $clog2(SLOT_COUNT);
	// Home bucket: q = (id * RECIP) >> SHIFT is the quotient or one below it,
	// so id - q * SLOT_COUNT lies below twice the slot count.
	localparam int SHIFT = KEY_W + IW;
	localparam int OPW   = (KEY_W + 1 > IW + 1) ? KEY_W + 1 : IW + 1;
	localparam logic [63:0]    RECIP_FULL = (64'd1 << SHIFT) / SLOT_COUNT;
	localparam logic [OPW-1:0] RECIP      = OPW'(RECIP_FULL);
	localparam logic [OPW-1:0] SLOTS_OP   = OPW'(SLOT_COUNT);
	localparam logic [IW:0]    SLOTS_REM  = (IW+1)'(SLOT_COUNT);
	localparam logic [IW-1:0]  LAST       = IW'(SLOT_COUNT - 1);

	lpnr_pkg::state_t  state_q, state_nx;
	lpnr_pkg::status_t res_status_q, res_status_nx;
	logic [NAME_WIDTH-1:0] res_name_q, res_name_nx;

	logic                  op_q;
	logic [KEY_W-1:0]      id_q;
	logic [NAME_WIDTH-1:0] name_q;
	logic [2*OPW-1:0]      prod_q;
	logic [IW-1:0]         home_q, slot_q, cnt_q, clr_q;
	logic                  armed_q;

	logic                  out_valid_q;
	lpnr_pkg::status_t     out_status_q;
	logic [NAME_WIDTH-1:0] out_name_q;

	// shared multiplier
	logic [OPW-1:0]   mul_a, mul_b;
	logic [2*OPW-1:0] mul_p;

	// remainder correction
	logic [OPW-1:0] rem_diff;
	logic [IW:0]    rem_raw, rem_fix;

	// RAM ports
	logic                  id_we, name_we;
	logic [IW-1:0]         waddr, raddr;
	logic [KEY_W-1:0]      id_wdata, id_rd;
	logic [NAME_WIDTH-1:0] name_rd;

	logic [KEY_W-1:0] key_in;
	logic             accept, emit_free, probe_hit, probe_empty, probe_last, probe_done;
	logic [IW-1:0]    slot_nx;

	assign key_in      = req.key_id[KEY_W-1:0];
	assign accept      = req.valid && req.ready;
	assign emit_free   = !out_valid_q || rsp.ready;
	assign probe_hit   = (id_rd == id_q);
	assign probe_empty = (id_rd == '0);
	assign probe_last  = (cnt_q == LAST);
	assign probe_done  = probe_hit || probe_empty || probe_last;
	assign slot_nx     = (slot_q == LAST) ? '0 : slot_q + 1'b1;

	assign mul_p    = mul_a * mul_b;
	assign rem_diff = OPW'(id_q) - prod_q[OPW-1:0];
	assign rem_raw  = rem_diff[IW:0];
	assign rem_fix  = (rem_raw >= SLOTS_REM) ? rem_raw - SLOTS_REM : rem_raw;

	lpnr_ram #(.WIDTH(KEY_W), .DEPTH(SLOT_COUNT)) u_id_ram (
		.clk   (clk),
		.we    (id_we),
		.waddr (waddr),
		.wdata (id_wdata),
		.raddr (raddr),
		.rdata (id_rd)
	);

	lpnr_ram #(.WIDTH(NAME_WIDTH), .DEPTH(SLOT_COUNT)) u_name_ram (
		.clk   (clk),
		.we    (name_we),
		.waddr (waddr),
		.wdata (name_q),
		.raddr (raddr),
		.rdata (name_rd)
	);

	// Next state and result selection.
	always_comb begin
		state_nx      = state_q;
		res_status_nx = res_status_q;
		res_name_nx   = res_name_q;
		unique case (state_q)
			lpnr_pkg::S_CLEAR: begin
				if (clr_q == LAST) state_nx = lpnr_pkg::S_IDLE;
			end
			lpnr_pkg::S_IDLE: begin
				if (req.valid) begin
					res_name_nx = '0;
					if (req.opcode == lpnr_pkg::OP_REGISTER && (!armed_q || key_in == '0)) begin
						// register before arming or with no id: drop it
						res_status_nx = lpnr_pkg::ST_IGNORED;
						state_nx      = lpnr_pkg::S_EMIT;
					end else if (req.opcode == lpnr_pkg::OP_LOOKUP && key_in == '0) begin
						res_status_nx = lpnr_pkg::ST_MISS;
						state_nx      = lpnr_pkg::S_EMIT;
					end else begin
						state_nx = lpnr_pkg::S_MUL1;
					end
				end
			end
			lpnr_pkg::S_MUL1:  state_nx = lpnr_pkg::S_MUL2;
			lpnr_pkg::S_MUL2:  state_nx = lpnr_pkg::S_REM;
			lpnr_pkg::S_REM:   state_nx = lpnr_pkg::S_ISSUE;
			lpnr_pkg::S_ISSUE: state_nx = lpnr_pkg::S_PROBE;
			lpnr_pkg::S_PROBE: begin
				if (probe_done) begin
					state_nx    = lpnr_pkg::S_EMIT;
					res_name_nx = '0;
					if (op_q == lpnr_pkg::OP_LOOKUP) begin
						if (probe_hit) begin
							res_status_nx = lpnr_pkg::ST_HIT;
							res_name_nx   = name_rd;
						end else begin
							res_status_nx = lpnr_pkg::ST_MISS;
						end
					end else begin
						res_status_nx = (probe_hit || probe_empty) ?
							lpnr_pkg::ST_PROBED : lpnr_pkg::ST_HOME;
					end
				end
			end
			lpnr_pkg::S_EMIT: begin
				if (emit_free) state_nx = lpnr_pkg::S_IDLE;
			end
			default: state_nx = lpnr_pkg::S_CLEAR;
		endcase
	end

	// Control outputs: handshake, RAM ports, multiplier operands.
	always_comb begin
		req.ready = (state_q == lpnr_pkg::S_IDLE);
		id_we     = 1'b0;
		name_we   = 1'b0;
		waddr     = slot_q;
		id_wdata  = id_q;
		raddr     = slot_q;
		mul_a     = OPW'(id_q);
		mul_b     = RECIP;
		unique case (state_q)
			lpnr_pkg::S_CLEAR: begin
				id_we    = 1'b1;
				waddr    = clr_q;
				id_wdata = '0;
			end
			lpnr_pkg::S_MUL2: begin
				mul_a = OPW'(prod_q >> SHIFT);
				mul_b = SLOTS_OP;
			end
			lpnr_pkg::S_PROBE: begin
				// fetch the next slot while this one is compared
				raddr = slot_nx;
				if (op_q == lpnr_pkg::OP_REGISTER) begin
					if (probe_hit || probe_empty) begin
						id_we   = 1'b1;
						name_we = 1'b1;
					end else if (probe_last) begin
						// table full of other ids: take over the home bucket
						id_we   = 1'b1;
						name_we = 1'b1;
						waddr   = home_q;
					end
				end
			end
			lpnr_pkg::S_IDLE, lpnr_pkg::S_MUL1, lpnr_pkg::S_REM,
			lpnr_pkg::S_ISSUE, lpnr_pkg::S_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpnr_pkg::S_CLEAR;
			clr_q       <= '0;
			armed_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == lpnr_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
			if (accept && req.opcode == lpnr_pkg::OP_LOOKUP) armed_q <= 1'b1;
			if (state_q == lpnr_pkg::S_EMIT && emit_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		res_status_q <= res_status_nx;
		res_name_q   <= res_name_nx;
		if (accept) begin
			op_q   <= req.opcode;
			id_q   <= key_in;
			name_q <= req.name_value;
		end
		if (state_q == lpnr_pkg::S_MUL1 || state_q == lpnr_pkg::S_MUL2) prod_q <= mul_p;
		if (state_q == lpnr_pkg::S_REM) begin
			home_q <= rem_fix[IW-1:0];
			slot_q <= rem_fix[IW-1:0];
			cnt_q  <= '0;
		end
		if (state_q == lpnr_pkg::S_PROBE) begin
			slot_q <= slot_nx;
			cnt_q  <= cnt_q + 1'b1;
		end
		if (state_q == lpnr_pkg::S_EMIT && emit_free) begin
			out_status_q <= res_status_q;
			out_name_q   <= res_name_q;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_status_q;
	assign rsp.name_out = out_name_q;

endmodule

### src/lpnr_checker.sv
// ----------------------------------------------------------------------------
// lpnr_checker: port-level checks for the name registry
// Watches both channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module lpnr_checker #(
	parameter int NAME_W = 64
) (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [2:0]        rsp_status,
	input logic [NAME_W-1:0] rsp_name_out
);
	// hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_name_out))
		else $error("stalled response changed or dropped");

	// drop the name on every status but a hit
	a_name_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != lpnr_pkg::ST_HIT |-> rsp_name_out == '0)
		else $error("name payload on a non-hit response");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status <= lpnr_pkg::ST_MISS)
		else $error("undefined status code");

	// one request at a time: busy right after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while the previous one is in flight");
endmodule

bind linear_probe_name_registry lpnr_checker #(.NAME_W(NAME_WIDTH)) u_lpnr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_name_out (rsp.name_out)
);
